// ----- src/assert_macros.svh -----
// Assertion macros shared by the form field extractor modules.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("assertion failed: condition does not hold");

// When ante holds, cons must hold in the same cycle.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: implication does not hold");

`endif

// ----- src/ffve_pkg.sv -----
// Shared types, character codes and helpers for the form field extractor.
// Depends on nothing; imported by every module of the block.
package ffve_pkg;

    // Characters with a meaning in a url-encoded body
    localparam logic [7:0] CHAR_PCT   = 8'h25;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_AMP   = 8'h26;
    localparam logic [7:0] CHAR_EQ    = 8'h3D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    // Configuration register indexes
    localparam logic [1:0] CFG_KEY_BYTES   = 2'd0;
    localparam logic [1:0] CFG_KEY_LENGTH  = 2'd1;
    localparam logic [1:0] CFG_VALUE_LIMIT = 2'd2;

    // Result kinds and status codes
    localparam logic       KIND_VALUE  = 1'b0;
    localparam logic       KIND_STATUS = 1'b1;
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // All results caused by one input byte
    typedef struct packed {
        logic [1:0]      nval;        // decoded value bytes, 0..3
        logic [2:0][7:0] vals;        // value bytes, first in vals[0]
        logic            has_status;  // end-of-body status follows the values
        logic [1:0]      status;
    } ffve_entry_t;

    // Queue fill flags seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } ffve_qstat_t;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
        end
        return d[3:0];
    endfunction

endpackage

// ----- src/ffve_front.sv -----
// Front end: configuration registers, key matcher and value decoder.
// Turns each accepted body byte into at most one queue entry. Uses ffve_pkg.
module ffve_front
    import ffve_pkg::*;
#(
    parameter int MAX_KEY_BYTES   = 8,
    parameter int MAX_VALUE_BYTES = 512
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // body_byte
    input  logic        s_tlast,     // end_of_body
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  ffve_qstat_t q_stat,
    output logic        push,
    output ffve_entry_t push_entry
);

    localparam int CNT_W = $clog2(MAX_VALUE_BYTES);
    localparam int LIM_W = (CNT_W > 9) ? CNT_W : 9;

    localparam logic [1:0] MODE_MATCH = 2'd0;
    localparam logic [1:0] MODE_SKIP  = 2'd1;
    localparam logic [1:0] MODE_VALUE = 2'd2;
    localparam logic [1:0] MODE_DONE  = 2'd3;

    localparam logic [1:0] PH_NONE  = 2'd0;
    localparam logic [1:0] PH_PCT   = 2'd1;
    localparam logic [1:0] PH_DIGIT = 2'd2;

    logic [63:0]      key_bytes_reg;
    logic [3:0]       key_length_reg;
    logic [8:0]       value_limit_reg;

    logic [1:0]       mode_reg, mode_next;
    logic [3:0]       kpos_reg, kpos_next;
    logic [1:0]       phase_reg, phase_next;
    logic [7:0]       held_reg, held_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             found_reg, found_next;

    logic             accept;
    logic [3:0]       klen;
    logic [7:0]       key_ch;
    logic [LIM_W-1:0] lim;
    logic [LIM_W-1:0] room;
    logic [1:0]       nacc;
    logic [1:0]       ncand;
    logic [2:0][7:0]  cand;
    logic [1:0]       status;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_stat.full;
    assign accept    = s_tvalid && s_tready;

    // Configuration registers, to be written only while idle; the block does not enforce it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_bytes_reg   <= 64'd0;
            key_length_reg  <= 4'd1;
            value_limit_reg <= 9'd511;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_KEY_BYTES:   key_bytes_reg   <= cfg_data;
                CFG_KEY_LENGTH:  key_length_reg  <= cfg_data[3:0];
                CFG_VALUE_LIMIT: value_limit_reg <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // Effective key length, current key character and output limit
    always_comb begin
        logic [LIM_W-1:0] vl;
        logic [LIM_W-1:0] cap;
        klen   = (key_length_reg > 4'(MAX_KEY_BYTES)) ? 4'(MAX_KEY_BYTES) : key_length_reg;
        key_ch = key_bytes_reg[{kpos_reg[2:0], 3'b000} +: 8];
        vl     = (value_limit_reg == 9'd0) ? LIM_W'(1) : LIM_W'(value_limit_reg);
        cap    = LIM_W'(MAX_VALUE_BYTES - 1);
        lim    = (vl > cap) ? cap : vl;
    end

    // Scan and decode one byte: next state plus candidate value bytes
    always_comb begin
        logic plain;
        mode_next  = mode_reg;
        kpos_next  = kpos_reg;
        phase_next = phase_reg;
        held_next  = held_reg;
        found_next = found_reg;
        cand       = '0;
        ncand      = 2'd0;
        plain      = 1'b1;
        case (mode_reg)
            MODE_MATCH: begin
                if (kpos_reg < klen) begin
                    if (s_tdata == key_ch) begin
                        kpos_next = kpos_reg + 4'd1;
                    end else if (s_tdata == CHAR_AMP) begin
                        kpos_next = 4'd0;
                    end else begin
                        mode_next = MODE_SKIP;
                    end
                end else if (s_tdata == CHAR_EQ) begin
                    found_next = 1'b1;
                    mode_next  = MODE_VALUE;
                end else if (s_tdata == CHAR_AMP) begin
                    kpos_next = 4'd0;
                end else begin
                    mode_next = MODE_SKIP;
                end
            end
            MODE_SKIP: begin
                if (s_tdata == CHAR_AMP) begin
                    mode_next = MODE_MATCH;
                    kpos_next = 4'd0;
                end
            end
            MODE_VALUE: begin
                // pending escape: complete it or flush it literally
                if (phase_reg == PH_PCT) begin
                    if (is_hex(s_tdata)) begin
                        held_next  = s_tdata;
                        phase_next = PH_DIGIT;
                        plain      = 1'b0;
                    end else begin
                        cand[ncand] = CHAR_PCT;
                        ncand       = ncand + 2'd1;
                        phase_next  = PH_NONE;
                    end
                end else if (phase_reg == PH_DIGIT) begin
                    if (is_hex(s_tdata)) begin
                        cand[ncand] = {hex_val(held_reg), hex_val(s_tdata)};
                        ncand       = ncand + 2'd1;
                        phase_next  = PH_NONE;
                        plain       = 1'b0;
                    end else begin
                        cand[ncand] = CHAR_PCT;
                        ncand       = ncand + 2'd1;
                        cand[ncand] = held_reg;
                        ncand       = ncand + 2'd1;
                        phase_next  = PH_NONE;
                    end
                end
                if (plain) begin
                    if (s_tdata == CHAR_PCT) begin
                        phase_next = PH_PCT;
                    end else if (s_tdata == CHAR_PLUS) begin
                        cand[ncand] = CHAR_SPACE;
                        ncand       = ncand + 2'd1;
                    end else if (s_tdata == CHAR_AMP) begin
                        mode_next = MODE_DONE;
                    end else begin
                        cand[ncand] = s_tdata;
                        ncand       = ncand + 2'd1;
                    end
                end
            end
            default: ;
        endcase
        // escape still open at end of body goes out literally
        if (s_tlast && mode_next == MODE_VALUE) begin
            if (phase_next != PH_NONE) begin
                cand[ncand] = CHAR_PCT;
                ncand       = ncand + 2'd1;
            end
            if (phase_next == PH_DIGIT) begin
                cand[ncand] = held_next;
                ncand       = ncand + 2'd1;
            end
        end
    end

    // Output limit: keep only the prefix that still fits
    always_comb begin
        room       = (LIM_W'(count_reg) >= lim) ? '0 : lim - LIM_W'(count_reg);
        nacc       = (room >= LIM_W'(ncand)) ? ncand : room[1:0];
        count_next = count_reg + CNT_W'(nacc);
        if (!found_next) begin
            status = ST_NOT_FOUND;
        end else if (count_next == '0) begin
            status = ST_EMPTY;
        end else begin
            status = ST_OK;
        end
    end

    assign push_entry.nval       = nacc;
    assign push_entry.vals       = cand;
    assign push_entry.has_status = s_tlast;
    assign push_entry.status     = status;
    assign push                  = accept && (nacc != 2'd0 || s_tlast);

    // Scan state; end of body returns everything to reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_MATCH;
            kpos_reg  <= 4'd0;
            phase_reg <= PH_NONE;
            held_reg  <= 8'd0;
            count_reg <= '0;
            found_reg <= 1'b0;
        end else if (accept) begin
            if (s_tlast) begin
                mode_reg  <= MODE_MATCH;
                kpos_reg  <= 4'd0;
                phase_reg <= PH_NONE;
                held_reg  <= 8'd0;
                count_reg <= '0;
                found_reg <= 1'b0;
            end else begin
                mode_reg  <= mode_next;
                kpos_reg  <= kpos_next;
                phase_reg <= phase_next;
                held_reg  <= held_next;
                count_reg <= count_next;
                found_reg <= found_next;
            end
        end
    end

endmodule

// ----- src/ffve_queue.sv -----
// Two-entry queue of result entries between front and back.
// Uses ffve_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ffve_queue
    import ffve_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  ffve_entry_t push_entry,
    input  logic        pop,
    output ffve_entry_t head,
    output ffve_qstat_t q_stat
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    ffve_entry_t      slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign head         = slots_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `ASSERT_IMPL(a_no_push_full, aclk, aresetn, push, !q_stat.full)
    `ASSERT_IMPL(a_no_pop_empty, aclk, aresetn, pop, !q_stat.empty)

endmodule

// ----- src/ffve_back.sv -----
// Back end: unpacks queue entries into one result beat each.
// Holds the output register. Uses ffve_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ffve_back
    import ffve_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  ffve_entry_t head,
    input  ffve_qstat_t q_stat,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,     // value_byte [7:0], status [9:8], zero [15:10]
    output logic        m_tuser,     // result_kind
    output logic        m_tlast      // last_of_run
);

    logic [1:0]  idx_reg;
    logic        valid_reg;
    logic [7:0]  byte_reg;
    logic [1:0]  status_reg;
    logic        kind_reg;
    logic        last_reg;

    logic        load;
    logic [2:0]  total;
    logic        is_last;
    logic        is_value;

    assign load     = !q_stat.empty && (!valid_reg || m_tready);
    assign total    = {1'b0, head.nval} + {2'b00, head.has_status};
    assign is_last  = ({1'b0, idx_reg} + 3'd1) == total;
    assign is_value = idx_reg < head.nval;
    assign pop      = load && is_last;

    // Walk through the head entry one result per beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            if (load) begin
                idx_reg   <= is_last ? 2'd0 : idx_reg + 2'd1;
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg   <= is_value ? KIND_VALUE : KIND_STATUS;
            byte_reg   <= is_value ? head.vals[idx_reg] : 8'd0;
            status_reg <= is_value ? ST_OK : head.status;
            last_reg   <= is_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'd0, status_reg, byte_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

    `ASSERT_IMPL(a_status_is_last, aclk, aresetn, m_tvalid && m_tuser == KIND_STATUS, m_tlast)
    `ASSERT_IMPL(a_head_not_blank, aclk, aresetn, !q_stat.empty, total != 3'd0)

endmodule

// ----- src/form_field_value_extractor.sv -----
// Url-encoded form field value extractor.
// The s_ channel takes one body byte per beat, tlast on the final byte of a body.
// The m_ channel gives decoded value bytes (tuser 0) and one end-of-body status
// (tuser 1: ok, key not found, empty value); tlast marks the last result that
// a given input byte caused. A byte may cause no result, or up to four when an
// escape is flushed at the end of a body.
// The cfg channel writes key_bytes (0), key_length (1) and value_limit (2), which
// the user writes only while the block is idle (not enforced); cfg_ready is always high.
// A result reaches m_ from its input beat through a queue slot and the output register.
// Throughput: one input byte per cycle while each byte causes at most one
// result and m_tready stays high; an input causing k results gives k output beats,
// and the two-entry queue between the decoder and the output stage sets how
// long the input can run ahead before s_tready drops.
// When the receiver stalls, the output beat holds, the queue fills and then
// s_tready goes low. Reset clears the scan state and the queue and loads the
// register defaults; no clearing pass is needed.
// Depends on ffve_pkg, ffve_front, ffve_queue and ffve_back.
module form_field_value_extractor
    import ffve_pkg::*;
#(
    parameter int MAX_KEY_BYTES   = 8,
    parameter int MAX_VALUE_BYTES = 512
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // body_byte [7:0]
    input  logic        s_tlast,     // end_of_body
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,     // value_byte [7:0], status [9:8], zero [15:10]
    output logic        m_tuser,     // result_kind
    output logic        m_tlast,     // last_of_run
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    ffve_qstat_t q_stat;
    ffve_entry_t push_entry;
    ffve_entry_t head;
    logic        push;
    logic        pop;

    ffve_front #(
        .MAX_KEY_BYTES   (MAX_KEY_BYTES),
        .MAX_VALUE_BYTES (MAX_VALUE_BYTES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_stat     (q_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    ffve_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_stat     (q_stat)
    );

    ffve_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
